>>> hdl/aids_pkg.sv
// ----------------------------------------------------------------------------
// aids_pkg
// Types and codes shared by the array insert / delete / search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package aids_pkg;

    localparam int POS_W   = 7;
    localparam int FPOS_W  = 6;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADPOS  = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_INS_WR,
        S_SHIFT_DN,
        S_SCAN,
        S_RD_ADDR,
        S_RD_DATA,
        S_FIN
    } t_state;

    typedef struct packed {
        t_op                      operation;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
    } t_req;

    typedef struct packed {
        t_status                  status;
        logic [FPOS_W-1:0]        found_position;
        logic signed [VAL_W-1:0]  read_value;
        logic [COUNT_W-1:0]       entry_count;
    } t_rsp;

endpackage

`default_nettype wire

>>> hdl/array_insert_delete_search_unit.sv
// ----------------------------------------------------------------------------
// array_insert_delete_search_unit
// Packed array of signed 32-bit entries with insert, delete, search and read.
// ----------------------------------------------------------------------------
// Insert at p shifts entries p..n-1 up one place and then writes the new
// value; delete shifts the entries above p down; search scans from entry 0
// to the first match; a rejected request goes straight to its result. One
// request at a time, the next taken in the cycle after the result leaves;
// the memory moves one entry per cycle.
// Synchronous reset empties the array; the entry memory is not cleared.
`default_nettype none

module array_insert_delete_search_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire aids_pkg::t_req i_req,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output aids_pkg::t_rsp      o_rsp
);
    import aids_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic [VAL_W-1:0] w_wr_data;
    logic [AW-1:0]    w_rd_addr;
    logic [VAL_W-1:0] w_rd_data;
    logic             w_res_valid;
    logic             w_res_ready;
    t_rsp             w_res;

    aids_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    aids_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req       (i_req),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    aids_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_res_ready (w_res_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

>>> hdl/aids_store.sv
// ----------------------------------------------------------------------------
// aids_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aids_store #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_wr_en,
    input  wire logic [AW-1:0]               i_wr_addr,
    input  wire logic [aids_pkg::VAL_W-1:0]  i_wr_data,
    input  wire logic [AW-1:0]               i_rd_addr,
    output logic      [aids_pkg::VAL_W-1:0]  o_rd_data
);
    import aids_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

>>> hdl/aids_out_stage.sv
// ----------------------------------------------------------------------------
// aids_out_stage
// Output register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module aids_out_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_res_valid,
    input  wire aids_pkg::t_rsp i_res,
    output logic                o_res_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output aids_pkg::t_rsp      o_rsp
);
    import aids_pkg::*;

    logic r_valid;
    logic n_valid;
    t_rsp r_rsp;
    logic w_load;

    assign o_res_ready = !r_valid || !i_out_stall;
    assign w_load      = i_res_valid && o_res_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rsp <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

>>> hdl/aids_ctrl.sv
// ----------------------------------------------------------------------------
// aids_ctrl
// Sequencer: walks the entry memory one address a cycle to shift, scan or
// read, and keeps the entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module aids_ctrl #(
    parameter int CAPACITY = 64,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire aids_pkg::t_req              i_req,
    output logic                             o_wr_en,
    output logic      [AW-1:0]               o_wr_addr,
    output logic      [aids_pkg::VAL_W-1:0]  o_wr_data,
    output logic      [AW-1:0]               o_rd_addr,
    input  wire logic [aids_pkg::VAL_W-1:0]  i_rd_data,
    output logic                             o_res_valid,
    output aids_pkg::t_rsp                   o_res,
    input  wire logic                        i_res_ready
);
    import aids_pkg::*;

    localparam int PW = (CW > POS_W) ? CW : POS_W;

    t_state           r_state,  n_state;
    logic [CW-1:0]    r_count,  n_count;
    logic [AW-1:0]    r_ra,     n_ra;
    logic [AW-1:0]    r_wa,     n_wa;
    logic [AW-1:0]    r_last,   n_last;
    logic             r_rd_on,  n_rd_on;
    logic             r_pend,   n_pend;
    logic [AW-1:0]    r_pos,    n_pos;
    logic [VAL_W-1:0] r_val,    n_val;
    t_status          r_status, n_status;
    logic [FPOS_W-1:0] r_fpos,  n_fpos;
    logic [VAL_W-1:0] r_rdval,  n_rdval;

    logic [PW-1:0]    w_pos_x;
    logic [PW-1:0]    w_cnt_x;
    logic [AW-1:0]    w_pos_a;
    logic [AW-1:0]    w_last_a;

    assign w_pos_x  = PW'(i_req.position);
    assign w_cnt_x  = PW'(r_count);
    assign w_pos_a  = w_pos_x[AW-1:0];
    assign w_last_a = AW'(r_count - CW'(1));

    assign o_rd_addr = r_ra;
    assign o_res     = '{status:         r_status,
                         found_position: r_fpos,
                         read_value:     r_rdval,
                         entry_count:    COUNT_W'(r_count)};

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ra     = r_ra;
        n_wa     = r_wa;
        n_last   = r_last;
        n_rd_on  = r_rd_on;
        n_pend   = r_pend;
        n_pos    = r_pos;
        n_val    = r_val;
        n_status = r_status;
        n_fpos   = r_fpos;
        n_rdval  = r_rdval;

        o_in_stall  = (r_state != S_IDLE);
        o_wr_en     = 1'b0;
        o_wr_addr   = r_wa;
        o_wr_data   = i_rd_data;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pos    = w_pos_a;
                    n_val    = i_req.value;
                    n_status = ST_OK;
                    n_fpos   = '0;
                    n_rdval  = '0;
                    n_rd_on  = 1'b1;
                    n_pend   = 1'b0;
                    unique case (i_req.operation)
                        OP_INSERT: begin
                            priority if (w_pos_x > w_cnt_x) begin
                                n_status = ST_BADPOS;
                                n_state  = S_FIN;
                            end else if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_FIN;
                            end else if (w_pos_x == w_cnt_x) begin
                                n_state = S_INS_WR;
                            end else begin
                                n_ra    = w_last_a;
                                n_last  = w_pos_a;
                                n_state = S_SHIFT_UP;
                            end
                        end
                        OP_DELETE: begin
                            priority if (w_pos_x >= w_cnt_x) begin
                                n_status = ST_BADPOS;
                                n_state  = S_FIN;
                            end else if (w_pos_a == w_last_a) begin
                                // last entry: nothing to move
                                n_count = r_count - CW'(1);
                                n_state = S_FIN;
                            end else begin
                                n_ra    = w_pos_a + AW'(1);
                                n_last  = w_last_a;
                                n_state = S_SHIFT_DN;
                            end
                        end
                        OP_SEARCH: begin
                            if (r_count == '0) begin
                                n_status = ST_MISSING;
                                n_state  = S_FIN;
                            end else begin
                                n_ra    = '0;
                                n_last  = w_last_a;
                                n_state = S_SCAN;
                            end
                        end
                        OP_READ: begin
                            if (w_pos_x >= w_cnt_x) begin
                                n_status = ST_BADPOS;
                                n_state  = S_FIN;
                            end else begin
                                n_ra    = w_pos_a;
                                n_state = S_RD_ADDR;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_SHIFT_UP: begin
                // read entry i-1 while writing the word read before it, from entry i, to i+1
                o_wr_en = r_pend;
                n_pend  = r_rd_on;
                n_wa    = r_ra + AW'(1);
                if (r_rd_on) begin
                    if (r_ra == r_last) begin
                        n_rd_on = 1'b0;
                    end else begin
                        n_ra = r_ra - AW'(1);
                    end
                end
                if (!r_rd_on && r_pend) begin
                    n_state = S_INS_WR;
                end
            end

            S_INS_WR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_pos;
                o_wr_data = r_val;
                n_count   = r_count + CW'(1);
                n_state   = S_FIN;
            end

            S_SHIFT_DN: begin
                o_wr_en = r_pend;
                n_pend  = r_rd_on;
                n_wa    = r_ra - AW'(1);
                if (r_rd_on) begin
                    if (r_ra == r_last) begin
                        n_rd_on = 1'b0;
                    end else begin
                        n_ra = r_ra + AW'(1);
                    end
                end
                if (!r_rd_on && r_pend) begin
                    n_count = r_count - CW'(1);
                    n_state = S_FIN;
                end
            end

            S_SCAN: begin
                n_pend = r_rd_on;
                n_wa   = r_ra;
                if (r_rd_on) begin
                    if (r_ra == r_last) begin
                        n_rd_on = 1'b0;
                    end else begin
                        n_ra = r_ra + AW'(1);
                    end
                end
                // first match ends the scan
                if (r_pend) begin
                    if (i_rd_data == r_val) begin
                        n_status = ST_OK;
                        n_fpos   = FPOS_W'(r_wa);
                        n_state  = S_FIN;
                    end else if (!r_rd_on) begin
                        n_status = ST_MISSING;
                        n_state  = S_FIN;
                    end
                end
            end

            S_RD_ADDR: begin
                n_state = S_RD_DATA;
            end

            S_RD_DATA: begin
                n_rdval = i_rd_data;
                n_fpos  = FPOS_W'(r_ra);
                n_state = S_FIN;
            end

            S_FIN: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rd_on <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rd_on <= n_rd_on;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra     <= n_ra;
        r_wa     <= n_wa;
        r_last   <= n_last;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
        r_fpos   <= n_fpos;
        r_rdval  <= n_rdval;
    end

endmodule

`default_nettype wire

>>> hdl/aids_checker.sv
// ----------------------------------------------------------------------------
// aids_checker
// Port-level checks for the array insert / delete / search unit.
// ----------------------------------------------------------------------------
`default_nettype none

module aids_checker #(
    parameter int CAPACITY = 64
) (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire aids_pkg::t_req i_req,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire aids_pkg::t_rsp o_rsp
);
    import aids_pkg::*;

    // nothing left over from before reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_rsp))
        else $error("stalled result changed");

    // one request in flight: an accepted request blocks the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while another is in progress");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CAPACITY > 127) || (o_rsp.entry_count <= CAPACITY))
        else $error("entry count above capacity");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rsp.status == ST_MISSING
        |-> o_rsp.found_position == '0 && o_rsp.read_value == '0)
        else $error("miss carries a position or value");

endmodule

bind array_insert_delete_search_unit aids_checker #(.CAPACITY(CAPACITY)) u_chk (.*);

`default_nettype wire
